### rtl/wrg_pkg.sv
`timescale 1ns / 1ps

package wrg_pkg;

    localparam int WORD_W     = 32;
    localparam int SEED_W     = 64;
    localparam int POOL_DEPTH = 16;
    localparam int WARMUP_W   = 7;

    localparam logic [SEED_W-1:0] SEED_MIX    = 64'h0102_0304_0506_0708;
    localparam logic [WORD_W-1:0] TEMPER_MASK = 32'hDA44_2D24;
    localparam logic [WARMUP_W-1:0] WARMUP_LAST = 7'd127;

    localparam logic [1:0] CMD_RESEED = 2'd0;
    localparam logic [1:0] CMD_RAW    = 2'd1;
    localparam logic [1:0] CMD_RANGED = 2'd2;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_UNSEEDED   = 2'd1;
    localparam logic [1:0] STATUS_ZERO_RANGE = 2'd2;

    // pool word 0 is always the word at the current position
    typedef logic [POOL_DEPTH-1:0][WORD_W-1:0] pool_t;

    function automatic pool_t well512_step(input pool_t cur);
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] c13;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c9;
        logic [WORD_W-1:0] c;
        logic [WORD_W-1:0] an;
        logic [WORD_W-1:0] d;
        logic [WORD_W-1:0] a15;
        pool_t             nxt;
        a   = cur[0];
        c13 = cur[13];
        b   = a ^ c13 ^ (a << 16) ^ (c13 << 15);
        c9  = cur[9];
        c   = c9 ^ (c9 >> 11);
        an  = b ^ c;
        d   = an ^ ((an << 5) & TEMPER_MASK);
        a15 = cur[15];
        for (int k = 2; k < POOL_DEPTH; k++) begin
            nxt[k] = cur[k-1];
        end
        nxt[1] = an;
        nxt[0] = a15 ^ b ^ d ^ (a15 << 2) ^ (b << 18) ^ (c << 28);
        return nxt;
    endfunction

endpackage

### rtl/well512_random_generator.sv
`timescale 1ns / 1ps
// Reseed runs 128 warm-up steps, one per cycle. A ranged draw runs a remainder pass of the
// bit-serial divider, draws one word per cycle until one is accepted, then runs a second pass.
// Error and unused commands go straight from idle to the done state.
// One item at a time; the output register lets the next item in while a result waits.
// Reset (aresetn low, synchronous) clears the seed, the pool and the seeded flag.
module well512_random_generator
    import wrg_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [SEED_W-1:0]        cfg_seed,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_cmd,
    input  logic [WORD_W-1:0]        s_range,
    input  logic signed [WORD_W-1:0] s_min_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [WORD_W-1:0]        m_value,
    output logic signed [WORD_W-1:0] m_offset_value,
    output logic [1:0]               m_status
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WARMUP,
        ST_DIV_MAX,
        ST_DRAW,
        ST_DIV_MOD,
        ST_DONE
    } state_t;

    state_t                   state_reg, state_next;
    logic [SEED_W-1:0]        seed_reg, seed_next;
    pool_t                    pool_reg, pool_next;
    logic                     seeded_reg, seeded_next;
    logic [WARMUP_W-1:0]      warm_cnt_reg, warm_cnt_next;
    logic [1:0]               cmd_reg, cmd_next;
    logic [WORD_W-1:0]        range_reg, range_next;
    logic signed [WORD_W-1:0] minv_reg, minv_next;
    logic [WORD_W-1:0]        maxv_reg, maxv_next;
    logic [WORD_W-1:0]        res_value_reg, res_value_next;
    logic [1:0]               res_status_reg, res_status_next;
    logic                     m_valid_reg, m_valid_next;
    logic [WORD_W-1:0]        m_value_reg, m_value_next;
    logic signed [WORD_W-1:0] m_offset_reg, m_offset_next;
    logic [1:0]               m_status_reg, m_status_next;

    pool_t             pool_step;
    logic [SEED_W-1:0] mixed;
    logic              div_start;
    logic [WORD_W-1:0] div_dividend;
    logic              div_busy;
    logic              div_done;
    logic [WORD_W-1:0] div_rem;
    logic              accept;
    logic              out_free;

    assign pool_step = well512_step(pool_reg);
    assign mixed     = seed_reg | SEED_MIX;
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    wrg_divider u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (range_reg),
        .busy      (div_busy),
        .done      (div_done),
        .remainder (div_rem)
    );

    always_comb begin
        state_next      = state_reg;
        seed_next       = seed_reg;
        pool_next       = pool_reg;
        seeded_next     = seeded_reg;
        warm_cnt_next   = warm_cnt_reg;
        cmd_next        = cmd_reg;
        range_next      = range_reg;
        minv_next       = minv_reg;
        maxv_next       = maxv_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_value_next    = m_value_reg;
        m_offset_next   = m_offset_reg;
        m_status_next   = m_status_reg;
        div_start       = 1'b0;
        div_dividend    = pool_step[0];

        if (cfg_valid && cfg_ready) begin
            seed_next = cfg_seed;
        end

        case (state_reg)
            ST_IDLE: begin
                div_dividend = '1;
                if (accept) begin
                    cmd_next        = s_cmd;
                    range_next      = s_range;
                    minv_next       = s_min_value;
                    res_value_next  = '0;
                    res_status_next = STATUS_OK;
                    state_next      = ST_DONE;
                    case (s_cmd)
                        CMD_RESEED: begin
                            for (int k = 0; k < POOL_DEPTH; k += 2) begin
                                pool_next[k]   = mixed[WORD_W-1:0];
                                pool_next[k+1] = mixed[SEED_W-1:WORD_W];
                            end
                            seeded_next   = 1'b1;
                            warm_cnt_next = '0;
                            state_next    = ST_WARMUP;
                        end
                        CMD_RAW: begin
                            if (!seeded_reg) begin
                                res_status_next = STATUS_UNSEEDED;
                            end else begin
                                pool_next      = pool_step;
                                res_value_next = pool_step[0];
                            end
                        end
                        CMD_RANGED: begin
                            if (!seeded_reg) begin
                                res_status_next = STATUS_UNSEEDED;
                            end else if (s_range == '0) begin
                                res_status_next = STATUS_ZERO_RANGE;
                            end else begin
                                range_next = s_range;
                                state_next = ST_DIV_MAX;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_WARMUP: begin
                pool_next     = pool_step;
                warm_cnt_next = warm_cnt_reg + 1'b1;
                if (warm_cnt_reg == WARMUP_LAST) begin
                    state_next = ST_DONE;
                end
            end
            ST_DIV_MAX: begin
                div_dividend = '1;
                div_start    = !div_busy && !div_done;
                if (div_done) begin
                    // range * floor(all-ones / range) = all-ones - remainder
                    maxv_next  = ~div_rem;
                    state_next = ST_DRAW;
                end
            end
            ST_DRAW: begin
                pool_next = pool_step;
                if (pool_step[0] <= maxv_reg) begin
                    div_start  = 1'b1;
                    state_next = ST_DIV_MOD;
                end
            end
            ST_DIV_MOD: begin
                if (div_done) begin
                    res_value_next = div_rem;
                    state_next     = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_value_next  = res_value_reg;
                    m_status_next = res_status_reg;
                    if ((cmd_reg == CMD_RAW || cmd_reg == CMD_RANGED)
                            && res_status_reg == STATUS_OK) begin
                        m_offset_next = minv_reg + $signed(res_value_reg);
                    end else begin
                        m_offset_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            seed_reg     <= '0;
            pool_reg     <= '0;
            seeded_reg   <= 1'b0;
            warm_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            seed_reg     <= seed_next;
            pool_reg     <= pool_next;
            seeded_reg   <= seeded_next;
            warm_cnt_reg <= warm_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
        cmd_reg        <= cmd_next;
        range_reg      <= range_next;
        minv_reg       <= minv_next;
        maxv_reg       <= maxv_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        m_value_reg    <= m_value_next;
        m_offset_reg   <= m_offset_next;
        m_status_reg   <= m_status_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_value        = m_value_reg;
    assign m_offset_value = m_offset_reg;
    assign m_status       = m_status_reg;

    a_div_start_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> (state_reg == ST_DIV_MAX || state_reg == ST_DRAW))
        else $error("divider started outside a ranged draw");

    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV_MAX || state_reg == ST_DIV_MOD))
        else $error("divider finished with nobody waiting");

    a_idle_div_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !div_busy)
        else $error("divider busy while accepting an item");

    a_done_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && out_free) |=> (m_valid && state_reg == ST_IDLE))
        else $error("result not presented");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != STATUS_OK) |-> (m_value == '0 && m_offset_value == '0))
        else $error("error item carries a nonzero value");

endmodule

### rtl/wrg_divider.sv
`timescale 1ns / 1ps

module wrg_divider
    import wrg_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [WORD_W-1:0] dividend,
    input  logic [WORD_W-1:0] divisor,
    output logic              busy,
    output logic              done,
    output logic [WORD_W-1:0] remainder
);

    localparam int CNT_W = $clog2(WORD_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_W - 1);

    logic              active_reg, active_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0] dvd_reg, dvd_next;
    logic [WORD_W-1:0] dvs_reg, dvs_next;
    logic [WORD_W:0]   trial;

    always_comb begin
        active_next = active_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        dvd_next    = dvd_reg;
        dvs_next    = dvs_reg;
        trial       = {rem_reg, dvd_reg[WORD_W-1]};
        if (start) begin
            active_next = 1'b1;
            cnt_next    = '0;
            rem_next    = '0;
            dvd_next    = dividend;
            dvs_next    = divisor;
        end else if (active_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = WORD_W'(trial - {1'b0, dvs_reg});
            end else begin
                rem_next = trial[WORD_W-1:0];
            end
            dvd_next = {dvd_reg[WORD_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST) begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            active_reg <= active_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
    end

    assign busy      = active_reg;
    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

### tb/well512_random_generator_tb.sv
`timescale 1ns / 1ps

module well512_random_generator_tb;
    import wrg_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int WARMUP_STEPS = int'(WARMUP_LAST) + 1;

    typedef struct packed {
        logic [WORD_W-1:0]        value;
        logic signed [WORD_W-1:0] offset_value;
        logic [1:0]               status;
    } draw_result_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [SEED_W-1:0]        cfg_seed = '0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [1:0]               s_cmd = CMD_RAW;
    logic [WORD_W-1:0]        s_range = '0;
    logic signed [WORD_W-1:0] s_min_value = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic [WORD_W-1:0]        m_value;
    logic signed [WORD_W-1:0] m_offset_value;
    logic [1:0]               m_status;

    // generator copy kept in step with the block
    logic [SEED_W-1:0] seed_reg;
    logic [WORD_W-1:0] well_pool [POOL_DEPTH];
    logic [3:0]        well_pos;
    bit                well_seeded;

    draw_result_t pending_draws[$];
    draw_result_t oldest_draw;

    bit idle_on = 1'b1;
    int fail_count;
    int n_items, n_reseeds, n_raw, n_ranged, n_rejected, n_errors, n_unused, n_seed_writes;

    well512_random_generator u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_seed       (cfg_seed),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_range        (s_range),
        .s_min_value    (s_min_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_value        (m_value),
        .m_offset_value (m_offset_value),
        .m_status       (m_status)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic logic [WORD_W-1:0] well_next_word();
        logic [3:0]        p;
        logic [WORD_W-1:0] a, b, c, d;
        p = well_pos;
        a = well_pool[p];
        c = well_pool[p + 4'd13];
        b = a ^ c ^ (a << 16) ^ (c << 15);
        c = well_pool[p + 4'd9];
        c = c ^ (c >> 11);
        a = b ^ c;
        well_pool[p] = a;
        d = a ^ ((a << 5) & TEMPER_MASK);
        p = p + 4'd15;
        well_pos = p;
        a = well_pool[p];
        well_pool[p] = a ^ b ^ d ^ (a << 2) ^ (b << 18) ^ (c << 28);
        return well_pool[p];
    endfunction

    function automatic void well_reseed();
        logic [SEED_W-1:0] mixed;
        logic [WORD_W-1:0] discard;
        mixed = seed_reg | SEED_MIX;
        for (int i = 0; i < POOL_DEPTH; i += 2) begin
            well_pool[i]   = mixed[31:0];
            well_pool[i+1] = mixed[63:32];
        end
        well_pos = '0;
        well_seeded = 1'b1;
        for (int i = 0; i < WARMUP_STEPS; i++) begin
            discard = well_next_word();
        end
    endfunction

    function automatic void predict_draw(input logic [1:0] cmd, input logic [WORD_W-1:0] span,
                                         input logic [WORD_W-1:0] minv);
        draw_result_t      res;
        logic [WORD_W-1:0] maxv;
        logic [WORD_W-1:0] word;
        res = '0;
        res.status = STATUS_OK;
        case (cmd)
            CMD_RESEED: begin
                well_reseed();
                n_reseeds++;
            end
            CMD_RAW, CMD_RANGED: begin
                if (!well_seeded) begin
                    res.status = STATUS_UNSEEDED;
                    n_errors++;
                end else if (cmd == CMD_RAW) begin
                    res.value = well_next_word();
                    res.offset_value = minv + res.value;
                    n_raw++;
                end else if (span == '0) begin
                    res.status = STATUS_ZERO_RANGE;
                    n_errors++;
                end else begin
                    maxv = span * (32'hFFFF_FFFF / span);
                    word = well_next_word();
                    while (word > maxv) begin
                        n_rejected++;
                        word = well_next_word();
                    end
                    res.value = word % span;
                    res.offset_value = minv + res.value;
                    n_ranged++;
                end
            end
            default: n_unused++;
        endcase
        pending_draws.push_back(res);
    endfunction

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_draws.size() == 0) begin
                $error("result with no expected item: value %h status %0d", m_value, m_status);
                fail_count++;
            end else begin
                oldest_draw = pending_draws.pop_front();
                if (m_value !== oldest_draw.value) begin
                    $error("value mismatch: expected %h, got %h", oldest_draw.value, m_value);
                    fail_count++;
                end
                if (m_offset_value !== oldest_draw.offset_value) begin
                    $error("offset_value mismatch: expected %h, got %h",
                           oldest_draw.offset_value, m_offset_value);
                    fail_count++;
                end
                if (m_status !== oldest_draw.status) begin
                    $error("status mismatch: expected %0d, got %0d",
                           oldest_draw.status, m_status);
                    fail_count++;
                end
            end
        end
    end

    // receiver back-pressure
    initial begin
        forever begin
            @(negedge aclk);
            if (idle_on && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(0, 5)) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        #4_000_000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic send_item(input logic [1:0] cmd, input logic [WORD_W-1:0] span,
                             input logic [WORD_W-1:0] minv);
        @(negedge aclk);
        s_valid     <= 1'b1;
        s_cmd       <= cmd;
        s_range     <= span;
        s_min_value <= minv;
        do @(posedge aclk); while (!s_ready);
        predict_draw(cmd, span, minv);
        n_items++;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat ($urandom_range(0, 5)) @(negedge aclk);
        end
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_draws.size() != 0) @(posedge aclk);
    endtask

    task automatic write_seed(input logic [SEED_W-1:0] seed);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_seed  <= seed;
        do @(posedge aclk); while (!cfg_ready);
        seed_reg = seed;
        n_seed_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [WORD_W-1:0] pick_range();
        case ($urandom_range(0, 5))
            0: return $urandom_range(1, 16);
            1: return 32'd1 << $urandom_range(0, 31);
            2: return $urandom() | 32'd1;
            3: return 32'h8000_0000 + $urandom_range(1, 255);
            4: return 32'hFFFF_FFFF - $urandom_range(0, 255);
            default: return $urandom_range(1, 1000);
        endcase
    endfunction

    task automatic random_item();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 3)
            send_item(CMD_RESEED, $urandom(), $urandom());
        else if (sel < 6)
            send_item(CMD_UNUSED, $urandom(), $urandom());
        else if (sel < 9)
            send_item(CMD_RANGED, '0, $urandom());
        else if (sel < 45)
            send_item(CMD_RAW, $urandom(), $urandom());
        else
            send_item(CMD_RANGED, pick_range(), $urandom());
    endtask

    task automatic test_before_seed();
        send_item(CMD_RAW, 32'd5, 32'h1234_5678);
        send_item(CMD_RANGED, 32'd5, 32'h7FFF_FFFF);
        send_item(CMD_RANGED, '0, 32'h8000_0000);
        send_item(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_seed_extremes();
        wait_idle();
        write_seed('0);
        send_item(CMD_RESEED, '0, '0);
        send_item(CMD_RAW, '0, '0);
        send_item(CMD_RAW, '0, 32'h7FFF_FFFF);
        wait_idle();
        write_seed('1);
        send_item(CMD_RESEED, '1, '1);
        send_item(CMD_RAW, '1, 32'h8000_0000);
        send_item(CMD_RANGED, 32'hFFFF_FFFF, 32'h8000_0000);
    endtask

    task automatic test_range_corners();
        send_item(CMD_RANGED, 32'd1, 32'h0000_0000);
        send_item(CMD_RANGED, 32'd2, 32'hFFFF_FFFF);
        send_item(CMD_RANGED, 32'h8000_0000, 32'h8000_0000);
        send_item(CMD_RANGED, 32'h8000_0001, 32'h7FFF_FFFF);
        send_item(CMD_RANGED, 32'h8000_0001, 32'h0000_0001);
        send_item(CMD_RANGED, '0, 32'h7FFF_FFFF);
        send_item(CMD_RANGED, 32'd7, 32'h7FFF_FFFF);
        send_item(CMD_RAW, 32'd3, 32'hFFFF_FFFF);
        send_item(CMD_UNUSED, '0, '0);
        send_item(CMD_RANGED, 32'hFFFF_FFFE, 32'h8000_0000);
    endtask

    task automatic test_random_phases();
        logic [SEED_W-1:0] seed;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: seed = 64'h8000_0000_0000_0000;
                1: seed = 64'h0000_0000_FFFF_FFFF;
                default: seed = {$urandom(), $urandom()};
            endcase
            wait_idle();
            write_seed(seed);
            send_item(CMD_RESEED, $urandom(), $urandom());
            repeat (110) random_item();
        end
    endtask

    task automatic test_back_to_back();
        wait_idle();
        idle_on = 1'b0;
        write_seed({$urandom(), $urandom()});
        send_item(CMD_RESEED, $urandom(), $urandom());
        repeat (100) random_item();
    endtask

    initial begin
        seed_reg    = '0;
        well_pos    = '0;
        well_seeded = 1'b0;
        for (int i = 0; i < POOL_DEPTH; i++) well_pool[i] = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_before_seed();
        test_seed_extremes();
        test_range_corners();
        test_random_phases();
        test_back_to_back();

        wait_idle();
        repeat (20) @(posedge aclk);
        $display("Sent %0d items: %0d reseeds, %0d raw draws, %0d ranged draws (%0d redraws)",
                 n_items, n_reseeds, n_raw, n_ranged, n_rejected);
        $display("Error status items %0d, unused command items %0d, seed writes %0d",
                 n_errors, n_unused, n_seed_writes);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### sim.f
rtl/wrg_pkg.sv
rtl/wrg_divider.sv
rtl/well512_random_generator.sv
tb/well512_random_generator_tb.sv
